[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbf assertion failed");

// Next-cycle implication, disabled during reset.
`define CBF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbf assertion failed");

`endif

[rtl/cbf_pkg.sv]
// Shared types and operation codes of the circular byte FIFO.
package cbf_pkg;

   localparam logic [2:0] KIND_PUT       = 3'd0;
   localparam logic [2:0] KIND_GET       = 3'd1;
   localparam logic [2:0] KIND_CLEAR     = 3'd2;
   localparam logic [2:0] KIND_BLOCK_PUT = 3'd3;
   localparam logic [2:0] KIND_BLOCK_GET = 3'd4;

   localparam logic [8:0] RING_SIZE_RESET = 9'd256;
   localparam logic [8:0] RING_SIZE_MIN   = 9'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [6:0] block_length;
      logic       first_of_block;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] data_out;
      logic [7:0] fill_level;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

[rtl/cbf_ptr_mod.sv]
// Bit-serial remainder unit that reduces both pointers modulo a new ring size.
module cbf_ptr_mod #(
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [$clog2(DEPTH+1)-1:0]        size,
   input  logic [$clog2(DEPTH)-1:0]          rd_raw,
   input  logic [$clog2(DEPTH)-1:0]          wr_raw,
   output cbf_pkg::mod_status_type           status,
   output logic [$clog2(DEPTH)-1:0]          rd_rem,
   output logic [$clog2(DEPTH)-1:0]          wr_rem
);

   localparam int PW   = $clog2(DEPTH);
   localparam int SW   = $clog2(DEPTH + 1);
   localparam int CNTW = $clog2(PW + 1);

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [PW-1:0]   rd_div_ff, rd_div_in, wr_div_ff, wr_div_in;
   logic [SW-1:0]   rd_rem_ff, rd_rem_in, wr_rem_ff, wr_rem_in;
   logic [SW:0]     rd_shift, wr_shift;

   always_comb begin
      rd_shift  = {rd_rem_ff, rd_div_ff[PW-1]};
      wr_shift  = {wr_rem_ff, wr_div_ff[PW-1]};
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      rd_div_in = rd_div_ff;
      wr_div_in = wr_div_ff;
      rd_rem_in = rd_rem_ff;
      wr_rem_in = wr_rem_ff;
      if (start) begin
         cnt_in    = CNTW'(PW);
         rd_div_in = rd_raw;
         wr_div_in = wr_raw;
         rd_rem_in = '0;
         wr_rem_in = '0;
      end else if (cnt_ff != '0) begin
         if (rd_shift >= {1'b0, size}) begin
            rd_shift = rd_shift - {1'b0, size};
         end
         if (wr_shift >= {1'b0, size}) begin
            wr_shift = wr_shift - {1'b0, size};
         end
         rd_rem_in = SW'(rd_shift);
         wr_rem_in = SW'(wr_shift);
         rd_div_in = rd_div_ff << 1;
         wr_div_in = wr_div_ff << 1;
         cnt_in    = cnt_ff - CNTW'(1);
         done_in   = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rd_div_ff <= rd_div_in;
      wr_div_ff <= wr_div_in;
      rd_rem_ff <= rd_rem_in;
      wr_rem_ff <= wr_rem_in;
   end

   assign status.busy = (cnt_ff != '0) || done_ff;
   assign status.done = done_ff;
   assign rd_rem      = PW'(rd_rem_ff);
   assign wr_rem      = PW'(wr_rem_ff);

endmodule

[rtl/circular_byte_fifo.sv]
// Circular byte FIFO: ring buffer with settable ring size and block transfers.
// An item is taken when start is high and busy is low; each result beat is
// shown for one cycle on rsp_strobe, in the cycle after the item (or the byte
// read) that causes it, and the receiver cannot hold it off. Put, get, clear
// and block-put bytes leave busy low, so one item per cycle while busy is low.
// A block get of N bytes, N nonzero, reads the ring memory once per cycle
// and holds busy until its last byte is read, giving N consecutive result
// beats. A write to csr_wdata holds busy while both pointers are reduced
// modulo the new size one bit per cycle. The ring memory needs no clearing
// after reset; software should issue a clear after changing the ring size.
module circular_byte_fifo #(
   parameter int DEPTH     = 256,
   parameter int MAX_BLOCK = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cbf_pkg::req_type req_beat,
   output logic             rsp_strobe,
   output cbf_pkg::rsp_type rsp_beat,
   input  logic             csr_we,
   input  logic [8:0]       csr_wdata
);

   localparam int PW = $clog2(DEPTH);
   localparam int SW = $clog2(DEPTH + 1);
   localparam int RESET_SIZE = (int'(cbf_pkg::RING_SIZE_RESET) > DEPTH) ?
                               DEPTH : int'(cbf_pkg::RING_SIZE_RESET);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BLOCK = 1'b1;

   logic [7:0]    ring_mem [DEPTH];
   logic [7:0]    mem_q_ff;
   logic          mem_we, mem_re;

   logic          state_ff, state_in;
   logic [SW-1:0] size_ff, size_in;
   logic [PW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [PW-1:0] rd_raw_ff, rd_raw_in, wr_raw_ff, wr_raw_in;
   logic          blk_ok_ff, blk_ok_in;
   logic [6:0]    cnt_ff, cnt_in;

   logic          strobe_ff, strobe_in;
   logic          ok_ff, ok_in;
   logic          last_ff, last_in;
   logic          sel_ff, sel_in;
   logic [7:0]    fill_ff, fill_in;

   logic [SW-1:0] fill_now, space_now, wr_plus, rd_plus;
   logic [PW-1:0] wr_inc, rd_inc;
   logic          accept;
   logic          len_fits_max;

   cbf_pkg::mod_status_type mod_status;
   logic [PW-1:0]           rd_rem, wr_rem;

   function automatic logic [SW-1:0] fill_calc(input logic [PW-1:0] w,
                                               input logic [PW-1:0] r,
                                               input logic [SW-1:0] s);
      logic [SW-1:0] wx, rx;
      wx = SW'(w);
      rx = SW'(r);
      return (wx >= rx) ? (wx - rx) : (wx + s - rx);
   endfunction

   cbf_ptr_mod #(
      .DEPTH(DEPTH)
   ) u_ptr_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_we),
      .size   (size_ff),
      .rd_raw (rd_raw_ff),
      .wr_raw (wr_raw_ff),
      .status (mod_status),
      .rd_rem (rd_rem),
      .wr_rem (wr_rem)
   );

   assign busy   = (state_ff == ST_BLOCK) || mod_status.busy;
   assign accept = start && !busy;

   always_comb begin
      if (csr_wdata < cbf_pkg::RING_SIZE_MIN) begin
         size_in = SW'(cbf_pkg::RING_SIZE_MIN);
      end else if (32'(csr_wdata) > 32'(DEPTH)) begin
         size_in = SW'(DEPTH);
      end else begin
         size_in = SW'(csr_wdata);
      end
   end

   always_comb begin
      fill_now     = fill_calc(wr_ff, rd_ff, size_ff);
      space_now    = size_ff - SW'(1) - fill_now;
      wr_plus      = SW'(wr_ff) + SW'(1);
      rd_plus      = SW'(rd_ff) + SW'(1);
      wr_inc       = (wr_plus == size_ff) ? '0 : PW'(wr_plus);
      rd_inc       = (rd_plus == size_ff) ? '0 : PW'(rd_plus);
      len_fits_max = (32'(req_beat.block_length) <= 32'(MAX_BLOCK));

      state_in  = state_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      rd_raw_in = rd_raw_ff;
      wr_raw_in = wr_raw_ff;
      blk_ok_in = blk_ok_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      strobe_in = 1'b0;
      ok_in     = 1'b0;
      last_in   = 1'b1;
      sel_in    = 1'b0;

      if (state_ff == ST_BLOCK) begin
         mem_re    = 1'b1;
         rd_in     = rd_inc;
         rd_raw_in = rd_inc;
         cnt_in    = cnt_ff - 7'd1;
         strobe_in = 1'b1;
         ok_in     = 1'b1;
         sel_in    = 1'b1;
         last_in   = (cnt_ff == 7'd1);
         if (cnt_ff == 7'd1) begin
            state_in = ST_IDLE;
         end
      end else if (mod_status.done) begin
         rd_in = rd_rem;
         wr_in = wr_rem;
      end else if (accept) begin
         strobe_in = 1'b1;
         unique case (req_beat.kind)
            cbf_pkg::KIND_PUT: begin
               if (space_now != '0) begin
                  mem_we    = 1'b1;
                  wr_in     = wr_inc;
                  wr_raw_in = wr_inc;
                  ok_in     = 1'b1;
               end
            end
            cbf_pkg::KIND_GET: begin
               if (fill_now != '0) begin
                  mem_re    = 1'b1;
                  rd_in     = rd_inc;
                  rd_raw_in = rd_inc;
                  ok_in     = 1'b1;
                  sel_in    = 1'b1;
               end
            end
            cbf_pkg::KIND_CLEAR: begin
               rd_in     = '0;
               wr_in     = '0;
               rd_raw_in = '0;
               wr_raw_in = '0;
               blk_ok_in = 1'b0;
               ok_in     = 1'b1;
            end
            cbf_pkg::KIND_BLOCK_PUT: begin
               if (req_beat.first_of_block) begin
                  if (req_beat.block_length == 7'd0) begin
                     blk_ok_in = 1'b0;
                     ok_in     = 1'b1;
                  end else if (len_fits_max &&
                               32'(req_beat.block_length) <= 32'(space_now)) begin
                     blk_ok_in = 1'b1;
                     mem_we    = 1'b1;
                     wr_in     = wr_inc;
                     wr_raw_in = wr_inc;
                     ok_in     = 1'b1;
                  end else begin
                     blk_ok_in = 1'b0;
                  end
               end else if (blk_ok_ff && space_now != '0) begin
                  mem_we    = 1'b1;
                  wr_in     = wr_inc;
                  wr_raw_in = wr_inc;
                  ok_in     = 1'b1;
               end
            end
            cbf_pkg::KIND_BLOCK_GET: begin
               if (fill_now == '0 || !len_fits_max ||
                   32'(req_beat.block_length) > 32'(fill_now)) begin
                  ok_in = 1'b0;
               end else if (req_beat.block_length == 7'd0) begin
                  ok_in = 1'b1;
               end else begin
                  mem_re    = 1'b1;
                  rd_in     = rd_inc;
                  rd_raw_in = rd_inc;
                  ok_in     = 1'b1;
                  sel_in    = 1'b1;
                  cnt_in    = req_beat.block_length - 7'd1;
                  last_in   = (req_beat.block_length == 7'd1);
                  if (req_beat.block_length != 7'd1) begin
                     state_in = ST_BLOCK;
                  end
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end

      fill_in = 8'(fill_calc(wr_in, rd_in, size_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_ff] <= req_beat.data_byte;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         size_ff   <= SW'(RESET_SIZE);
         rd_ff     <= '0;
         wr_ff     <= '0;
         rd_raw_ff <= '0;
         wr_raw_ff <= '0;
         blk_ok_ff <= 1'b0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
         rd_raw_ff <= rd_raw_in;
         wr_raw_ff <= wr_raw_in;
         blk_ok_ff <= blk_ok_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            size_ff <= size_in;
         end
      end
      ok_ff   <= ok_in;
      last_ff <= last_in;
      sel_ff  <= sel_in;
      fill_ff <= fill_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_beat.ok         = ok_ff;
   assign rsp_beat.data_out   = sel_ff ? mem_q_ff : 8'd0;
   assign rsp_beat.fill_level = fill_ff;
   assign rsp_beat.last       = last_ff;

endmodule

[rtl/cbf_checker.sv]
// Port-level checker for the circular byte FIFO and its bind.
`include "assert_macros.svh"

module cbf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input cbf_pkg::rsp_type rsp_beat
);

   `CBF_ASSERT_NXT(a_accept_gives_beat, clock, reset, start && !busy, rsp_strobe)
   `CBF_ASSERT_IMP(a_refused_no_data, clock, reset, rsp_strobe && !rsp_beat.ok, rsp_beat.data_out == 8'd0)
   `CBF_ASSERT_IMP(a_mid_block_ok, clock, reset, rsp_strobe && !rsp_beat.last, rsp_beat.ok && busy)
   `CBF_ASSERT_NXT(a_block_continues, clock, reset, rsp_strobe && !rsp_beat.last, rsp_strobe)

endmodule

bind circular_byte_fifo cbf_checker u_cbf_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the circular byte FIFO: directed table, then random traffic.
module testbench;

   localparam int unsigned RING_DEPTH  = 256;
   localparam int unsigned BLOCK_MAX   = 64;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam logic [2:0]  KIND_RSVD_LO = 3'd5;
   localparam logic [2:0]  KIND_RSVD_HI = 3'd7;

   typedef struct packed {
      cbf_pkg::req_type req;
      logic             typed;
      cbf_pkg::rsp_type beat;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   cbf_pkg::req_type req_beat;
   logic             rsp_strobe;
   cbf_pkg::rsp_type rsp_beat;
   logic             csr_we;
   logic [8:0]       csr_wdata;

   logic [7:0]  ring_mem [RING_DEPTH];
   int unsigned rd_ptr = 0;
   int unsigned wr_ptr = 0;
   logic        blk_open = 1'b0;
   logic [8:0]  ring_size_q = cbf_pkg::RING_SIZE_RESET;

   cbf_pkg::rsp_type due_rsp [$];
   int unsigned      typed_seq [$];
   cbf_pkg::rsp_type typed_beat [$];
   int unsigned taken_items = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   logic        idle_en = 1'b1;

   circular_byte_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_beat   (req_beat),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned cur_size();
      int unsigned s;
      s = 32'(ring_size_q);
      if (s < 2) s = 2;
      if (s > RING_DEPTH) s = RING_DEPTH;
      return s;
   endfunction

   function automatic int unsigned ring_level(input int unsigned s);
      int unsigned r;
      int unsigned w;
      r = rd_ptr % s;
      w = wr_ptr % s;
      return (w >= r) ? (w - r) : (w + s - r);
   endfunction

   function automatic void ring_push(input int unsigned s, input logic [7:0] b);
      int unsigned p;
      p = wr_ptr % s;
      ring_mem[p] = b;
      wr_ptr = (p + 1) % s;
   endfunction

   function automatic logic [7:0] ring_pop(input int unsigned s);
      int unsigned p;
      p = rd_ptr % s;
      rd_ptr = (p + 1) % s;
      return ring_mem[p];
   endfunction

   function automatic void predict_rsp(input cbf_pkg::req_type r);
      int unsigned      s;
      int unsigned      fill;
      int unsigned      space;
      int unsigned      i;
      logic             ok;
      logic [7:0]       dout;
      cbf_pkg::rsp_type beat;
      s = cur_size();
      fill = ring_level(s);
      space = s - 1 - fill;
      ok = 1'b0;
      dout = '0;
      unique case (r.kind)
         cbf_pkg::KIND_PUT: begin
            if (space > 0) begin
               ring_push(s, r.data_byte);
               ok = 1'b1;
            end
         end
         cbf_pkg::KIND_GET: begin
            if (fill > 0) begin
               dout = ring_pop(s);
               ok = 1'b1;
            end
         end
         cbf_pkg::KIND_CLEAR: begin
            rd_ptr = 0;
            wr_ptr = 0;
            blk_open = 1'b0;
            ok = 1'b1;
         end
         cbf_pkg::KIND_BLOCK_PUT: begin
            if (r.first_of_block) begin
               if (r.block_length == 0) begin
                  blk_open = 1'b0;
                  ok = 1'b1;
               end else if (r.block_length <= BLOCK_MAX && r.block_length <= space) begin
                  blk_open = 1'b1;
                  ring_push(s, r.data_byte);
                  ok = 1'b1;
               end else begin
                  blk_open = 1'b0;
               end
            end else if (blk_open && space > 0) begin
               ring_push(s, r.data_byte);
               ok = 1'b1;
            end
         end
         cbf_pkg::KIND_BLOCK_GET: begin
            if (fill != 0 && r.block_length <= fill && r.block_length <= BLOCK_MAX) begin
               if (r.block_length == 0) begin
                  ok = 1'b1;
               end else begin
                  for (i = 0; i < r.block_length; i++) begin
                     beat.ok = 1'b1;
                     beat.data_out = ring_pop(s);
                     beat.fill_level = 8'(ring_level(s));
                     beat.last = (i + 1 == r.block_length);
                     due_rsp.push_back(beat);
                  end
                  return;
               end
            end
         end
         default: begin
         end
      endcase
      beat.ok = ok;
      beat.data_out = dout;
      beat.fill_level = 8'(ring_level(s));
      beat.last = 1'b1;
      due_rsp.push_back(beat);
   endfunction

   always @(posedge clock) begin : rsp_watch
      int unsigned      n0;
      cbf_pkg::rsp_type exp_beat;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_rsp.size() == 0) begin
               err_count++;
               $display("%0t unexpected rsp beat: ok=%0d data=%02h fill=%0d last=%0d",
                        $time, rsp_beat.ok, rsp_beat.data_out, rsp_beat.fill_level,
                        rsp_beat.last);
            end else begin
               exp_beat = due_rsp.pop_front();
               if (rsp_beat !== exp_beat) begin
                  err_count++;
                  $display("%0t rsp mismatch: exp ok=%0d data=%02h fill=%0d last=%0d",
                           $time, exp_beat.ok, exp_beat.data_out, exp_beat.fill_level,
                           exp_beat.last);
                  $display("%0t               got ok=%0d data=%02h fill=%0d last=%0d",
                           $time, rsp_beat.ok, rsp_beat.data_out, rsp_beat.fill_level,
                           rsp_beat.last);
               end
            end
         end
         if (start && !busy) begin
            n0 = due_rsp.size();
            predict_rsp(req_beat);
            if (typed_seq.size() != 0 && typed_seq[0] == taken_items) begin
               while (due_rsp.size() > n0) void'(due_rsp.pop_back());
               due_rsp.push_back(typed_beat[0]);
               void'(typed_seq.pop_front());
               void'(typed_beat.pop_front());
            end
            taken_items++;
         end
         if (csr_we) ring_size_q = csr_wdata;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic cbf_pkg::req_type rand_req(input logic [2:0] kind);
      cbf_pkg::req_type r;
      r.kind = kind;
      r.data_byte = 8'($urandom_range(255));
      r.block_length = 7'($urandom_range(64));
      r.first_of_block = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic plan_row_type dir_row(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [6:0] len, input logic first,
                                            input logic typed, input logic ok,
                                            input logic [7:0] dout, input logic [7:0] fill);
      plan_row_type row;
      row.req.kind = kind;
      row.req.data_byte = data;
      row.req.block_length = len;
      row.req.first_of_block = first;
      row.typed = typed;
      row.beat.ok = ok;
      row.beat.data_out = dout;
      row.beat.fill_level = fill;
      row.beat.last = 1'b1;
      return row;
   endfunction

   // hold the beat until taken, then maybe go idle for a burst
   task automatic send_beat(input cbf_pkg::req_type r);
      int unsigned seen;
      seen = taken_items;
      start <= 1'b1;
      req_beat <= r;
      do @(negedge clock); while (taken_items == seen);
      if (idle_en && $urandom_range(4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic drain_rsp();
      start <= 1'b0;
      do @(negedge clock); while (due_rsp.size() != 0);
   endtask

   task automatic set_ring_size(input logic [8:0] v);
      int unsigned held;
      drain_rsp();
      repeat (2) @(negedge clock);
      held = ring_level(cur_size());
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      while (busy) @(negedge clock);
      if (held != 0) send_beat(rand_req(cbf_pkg::KIND_CLEAR));
   endtask

   task automatic mixed_traffic(input int unsigned n);
      cbf_pkg::req_type r;
      int unsigned base;
      int unsigned pick;
      int unsigned blen;
      int unsigned n_follow;
      int unsigned brk;
      int unsigned f;
      int unsigned sel;
      base = taken_items;
      while (taken_items - base < n) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send_beat(rand_req(cbf_pkg::KIND_PUT));
         end else if (pick < 50) begin
            send_beat(rand_req(cbf_pkg::KIND_GET));
         end else if (pick < 65) begin
            blen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 6);
            n_follow = (blen > 0) ? blen - 1 : 0;
            brk = $urandom_range(9);
            if (brk == 0 && n_follow > 0) n_follow = $urandom_range(0, n_follow - 1);
            else if (brk == 1) n_follow++;
            r = rand_req(cbf_pkg::KIND_BLOCK_PUT);
            r.first_of_block = 1'b1;
            r.block_length = 7'(blen);
            send_beat(r);
            repeat (n_follow) begin
               r = rand_req(cbf_pkg::KIND_BLOCK_PUT);
               r.first_of_block = 1'b0;
               send_beat(r);
            end
         end else if (pick < 82) begin
            f = ring_level(cur_size());
            sel = $urandom_range(9);
            r = rand_req(cbf_pkg::KIND_BLOCK_GET);
            if (f == 0) r.block_length = 7'($urandom_range(3));
            else if (sel < 7) r.block_length = 7'($urandom_range(1, (f > 64) ? 64 : f));
            else if (sel == 7) r.block_length = '0;
            else if (sel == 8) r.block_length = 7'((f < 64) ? f + 1 : 65);
            send_beat(r);
         end else if (pick < 87) begin
            send_beat(rand_req(cbf_pkg::KIND_CLEAR));
         end else begin
            r = rand_req(cbf_pkg::KIND_BLOCK_PUT);
            r.first_of_block = 1'b0;
            send_beat(r);
         end
         if ($urandom_range(39) == 0) drain_rsp();
      end
   endtask

   initial begin : stimulus
      plan_row_type     plan [$];
      logic [8:0]       ring_plan [11];
      cbf_pkg::req_type r;
      int               ph;
      logic [8:0]       v;
      reset = 1'b1;
      start = 1'b0;
      req_beat = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      plan.push_back(dir_row(cbf_pkg::KIND_GET,       8'h5A, 7'd9,   1'b1, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_GET, 8'h00, 7'd1,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_GET, 8'h00, 7'd0,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_PUT,       8'h00, 7'd0,   1'b0, 1'b1, 1'b1, 8'h00,
                             8'd1));
      plan.push_back(dir_row(cbf_pkg::KIND_PUT,       8'hFF, 7'd64,  1'b1, 1'b1, 1'b1, 8'h00,
                             8'd2));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_GET, 8'hFF, 7'd0,   1'b1, 1'b1, 1'b1, 8'h00,
                             8'd2));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_GET, 8'h00, 7'd3,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd2));
      plan.push_back(dir_row(cbf_pkg::KIND_GET,       8'hFF, 7'd64,  1'b0, 1'b1, 1'b1, 8'h00,
                             8'd1));
      plan.push_back(dir_row(cbf_pkg::KIND_GET,       8'h00, 7'd0,   1'b1, 1'b1, 1'b1, 8'hFF,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h33, 7'd0,   1'b1, 1'b1, 1'b1, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h44, 7'd2,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'hA5, 7'd3,   1'b1, 1'b1, 1'b1, 8'h00,
                             8'd1));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h5A, 7'd3,   1'b0, 1'b1, 1'b1, 8'h00,
                             8'd2));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'hC3, 7'd3,   1'b0, 1'b1, 1'b1, 8'h00,
                             8'd3));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h0F, 7'd3,   1'b0, 1'b0, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_GET, 8'h00, 7'd4,   1'b1, 1'b0, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(KIND_RSVD_HI,            8'hFF, 7'd64,  1'b1, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(KIND_RSVD_LO,            8'h12, 7'd1,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h77, 7'd100, 1'b1, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_BLOCK_PUT, 8'h66, 7'd1,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_PUT,       8'h81, 7'd0,   1'b0, 1'b1, 1'b1, 8'h00,
                             8'd1));
      plan.push_back(dir_row(cbf_pkg::KIND_CLEAR,     8'hFF, 7'd127, 1'b1, 1'b1, 1'b1, 8'h00,
                             8'd0));
      plan.push_back(dir_row(cbf_pkg::KIND_GET,       8'h00, 7'd0,   1'b0, 1'b1, 1'b0, 8'h00,
                             8'd0));
      foreach (plan[i]) begin
         if (plan[i].typed) begin
            typed_seq.push_back(taken_items);
            typed_beat.push_back(plan[i].beat);
         end
         send_beat(plan[i].req);
      end

      // fill past one block, then probe the block-get limits
      r = rand_req(cbf_pkg::KIND_BLOCK_PUT);
      r.first_of_block = 1'b1;
      r.block_length = 7'd64;
      send_beat(r);
      repeat (63) begin
         r = rand_req(cbf_pkg::KIND_BLOCK_PUT);
         r.first_of_block = 1'b0;
         send_beat(r);
      end
      repeat (6) send_beat(rand_req(cbf_pkg::KIND_PUT));
      r = rand_req(cbf_pkg::KIND_BLOCK_GET);
      r.block_length = 7'd127;
      send_beat(r);
      r.block_length = 7'd65;
      send_beat(r);
      r.block_length = 7'd64;
      send_beat(r);
      drain_rsp();
      r.block_length = 7'd7;
      send_beat(r);
      r.block_length = 7'd6;
      send_beat(r);

      ring_plan = '{9'd2, 9'd0, 9'd1, 9'd3, 9'd17, 9'd511, 9'd300, 9'd255, 9'd5, 9'd0,
                    9'd256};
      for (ph = 0; ph < 11; ph++) begin
         v = ring_plan[ph];
         if (ph == 9) v = 9'($urandom_range(2, 40));
         if (ph == 10) idle_en = 1'b0;
         set_ring_size(v);
         mixed_traffic(25);
      end

      drain_rsp();
      repeat (8) @(negedge clock);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/cbf_pkg.sv
rtl/cbf_ptr_mod.sv
rtl/circular_byte_fifo.sv
rtl/cbf_checker.sv
tb/testbench.sv
